// File: hdl/wpc_pkg.sv
// Package for the window photometry and centroid unit.
// Holds word types, field widths, the queue job type and the back-end states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wpc_pkg;

  // Field widths of the channel words
  localparam int PIX_W = 16;
  localparam int WGT_W = 9;
  localparam int AP_W  = 22;
  localparam int WT_W  = 30;
  localparam int MOM_W = 24;
  localparam int CEN_W = 11;

  // Bits of the sample that take part in the sums
  localparam int PIXEL_BITS = 16;

  // Centroid fraction bits
  localparam int CEN_FRAC = 8;

  // Default window side
  localparam int WPC_WINDOW_SIDE = 6;

  // Division datapath: numerator is (moment << CEN_FRAC) + aperture / 2
  localparam int NUM_W = MOM_W + CEN_FRAC + 2;
  localparam int CNT_W = $clog2(CEN_W);

  // Job queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [WGT_W-1:0] weight;
  } in_word_t;

  typedef struct packed {
    logic [AP_W-1:0]  aperture_sum;
    logic [WT_W-1:0]  weighted_sum;
    logic [CEN_W-1:0] centroid_x;
    logic [CEN_W-1:0] centroid_y;
    logic             centroid_valid;
  } out_word_t;

  // Sums of one finished window
  typedef struct packed {
    logic [AP_W-1:0]  aperture;
    logic [WT_W-1:0]  weighted;
    logic [MOM_W-1:0] col_moment;
    logic [MOM_W-1:0] row_moment;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

`default_nettype wire

// File: hdl/wpc_front.sv
// Front end: accepts pixel words, keeps the window position and the four
// saturating sums, and pushes a job at the last pixel. Uses wpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpc_front
  import wpc_pkg::*;
#(
  parameter int WINDOW_SIDE = WPC_WINDOW_SIDE
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  input  wire logic     q_full,
  output logic          q_push,
  output job_t          q_job
);

  localparam int PW = $clog2(WINDOW_SIDE);
  localparam int MW = PIXEL_BITS + PW + 1;
  localparam int WPW = PIXEL_BITS + WGT_W;

  logic [PW-1:0]    col_r, col_nxt;
  logic [PW-1:0]    row_r, row_nxt;
  logic [AP_W-1:0]  ap_r, ap_nxt;
  logic [WT_W-1:0]  wt_r, wt_nxt;
  logic [MOM_W-1:0] cm_r, cm_nxt;
  logic [MOM_W-1:0] rm_r, rm_nxt;

  logic [PIXEL_BITS-1:0] pix;
  logic                  nz;
  logic                  accept;
  logic                  last;
  logic                  col_end;
  logic [AP_W:0]         ap_sum;
  logic [WPW-1:0]        w_prod;
  logic [WT_W:0]         wt_sum;
  logic [MW-1:0]         c_prod;
  logic [MW-1:0]         r_prod;
  logic [MOM_W:0]        cm_sum;
  logic [MOM_W:0]        rm_sum;
  logic [AP_W-1:0]       ap_upd;
  logic [WT_W-1:0]       wt_upd;
  logic [MOM_W-1:0]      cm_upd;
  logic [MOM_W-1:0]      rm_upd;

  assign pix      = in_word.pixel[PIXEL_BITS-1:0];
  assign nz       = (in_word.weight != '0);
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign col_end  = (col_r == PW'(WINDOW_SIDE - 1));
  assign last     = col_end && (row_r == PW'(WINDOW_SIDE - 1));

  // Products of this pixel
  assign w_prod = pix * in_word.weight;
  assign c_prod = pix * MW'({1'b0, col_r} + 1'b1);
  assign r_prod = pix * MW'({1'b0, row_r} + 1'b1);

  // Saturating sums
  assign ap_sum = {1'b0, ap_r} + (AP_W + 1)'(pix);
  assign wt_sum = {1'b0, wt_r} + (WT_W + 1)'(w_prod);
  assign cm_sum = {1'b0, cm_r} + (MOM_W + 1)'(c_prod);
  assign rm_sum = {1'b0, rm_r} + (MOM_W + 1)'(r_prod);

  always_comb begin
    ap_upd = ap_r;
    cm_upd = cm_r;
    rm_upd = rm_r;
    if (nz) begin
      ap_upd = ap_sum[AP_W] ? '1 : ap_sum[AP_W-1:0];
      cm_upd = cm_sum[MOM_W] ? '1 : cm_sum[MOM_W-1:0];
      rm_upd = rm_sum[MOM_W] ? '1 : rm_sum[MOM_W-1:0];
    end
    wt_upd = wt_sum[WT_W] ? '1 : wt_sum[WT_W-1:0];
  end

  assign q_push = accept && last;
  assign q_job  = '{aperture: ap_upd, weighted: wt_upd, col_moment: cm_upd,
                    row_moment: rm_upd};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    ap_nxt  = ap_r;
    wt_nxt  = wt_r;
    cm_nxt  = cm_r;
    rm_nxt  = rm_r;
    if (accept) begin
      if (last) begin
        // window done: clear for the next one
        col_nxt = '0;
        row_nxt = '0;
        ap_nxt  = '0;
        wt_nxt  = '0;
        cm_nxt  = '0;
        rm_nxt  = '0;
      end else begin
        ap_nxt = ap_upd;
        wt_nxt = wt_upd;
        cm_nxt = cm_upd;
        rm_nxt = rm_upd;
        if (col_end) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ap_r  <= '0;
      wt_r  <= '0;
      cm_r  <= '0;
      rm_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ap_r  <= ap_nxt;
      wt_r  <= wt_nxt;
      cm_r  <= cm_nxt;
      rm_r  <= rm_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/wpc_queue.sv
// Short job queue between the front end and the divider back end.
// Register-based FIFO of job_t words. Uses wpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpc_queue
  import wpc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      pop_valid,
  output job_t      pop_job
);

  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  job_t           mem_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full      = (count_r == QCW'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + QCW'(do_push) - QCW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue pop while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// File: hdl/wpc_back.sv
// Back end: takes one job from the queue, divides both moments by the
// aperture sum one quotient bit a cycle unless that sum is zero, and holds
// the result word. Uses wpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpc_back
  import wpc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_word_t out_word
);

  back_state_t      st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AP_W-1:0]  ap_r, ap_nxt;
  logic [WT_W-1:0]  wt_r, wt_nxt;
  logic [NUM_W-1:0] remx_r, remx_nxt;
  logic [NUM_W-1:0] remy_r, remy_nxt;
  logic [NUM_W-1:0] div_r, div_nxt;
  logic [CEN_W-1:0] qx_r, qx_nxt;
  logic [CEN_W-1:0] qy_r, qy_nxt;
  logic             satx_r, satx_nxt;
  logic             saty_r, saty_nxt;
  out_word_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [NUM_W-1:0] half_ap;
  logic [NUM_W-1:0] num_x;
  logic [NUM_W-1:0] num_y;
  logic [NUM_W-1:0] lim;
  logic             gex;
  logic             gey;
  logic [CEN_W-1:0] qx_step;
  logic [CEN_W-1:0] qy_step;

  // Rounded numerators and the saturation limit (quotient >= 2^CEN_W)
  assign half_ap = NUM_W'(q_job.aperture >> 1);
  assign num_x   = NUM_W'({q_job.col_moment, CEN_FRAC'(0)}) + half_ap;
  assign num_y   = NUM_W'({q_job.row_moment, CEN_FRAC'(0)}) + half_ap;
  assign lim     = NUM_W'(q_job.aperture) << CEN_W;

  // One restoring step per cycle
  assign gex     = (remx_r >= div_r);
  assign gey     = (remy_r >= div_r);
  assign qx_step = {qx_r[CEN_W-2:0], gex};
  assign qy_step = {qy_r[CEN_W-2:0], gey};

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    ap_nxt        = ap_r;
    wt_nxt        = wt_r;
    remx_nxt      = remx_r;
    remy_nxt      = remy_r;
    div_nxt       = div_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    satx_nxt      = satx_r;
    saty_nxt      = saty_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          ap_nxt = q_job.aperture;
          wt_nxt = q_job.weighted;
          if (q_job.aperture == '0) begin
            // empty aperture: no division
            out_nxt = '{aperture_sum: q_job.aperture, weighted_sum: q_job.weighted,
                        centroid_x: '0, centroid_y: '0, centroid_valid: 1'b0};
            out_valid_nxt = 1'b1;
            st_nxt        = BK_OUT;
          end else begin
            remx_nxt = num_x;
            remy_nxt = num_y;
            satx_nxt = (num_x >= lim);
            saty_nxt = (num_y >= lim);
            div_nxt  = NUM_W'(q_job.aperture) << (CEN_W - 1);
            qx_nxt   = '0;
            qy_nxt   = '0;
            cnt_nxt  = CNT_W'(CEN_W - 1);
            st_nxt   = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        remx_nxt = gex ? remx_r - div_r : remx_r;
        remy_nxt = gey ? remy_r - div_r : remy_r;
        qx_nxt   = qx_step;
        qy_nxt   = qy_step;
        div_nxt  = div_r >> 1;
        if (cnt_r == '0) begin
          out_nxt = '{aperture_sum: ap_r, weighted_sum: wt_r,
                      centroid_x: satx_r ? '1 : qx_step,
                      centroid_y: saty_r ? '1 : qy_step,
                      centroid_valid: 1'b1};
          out_valid_nxt = 1'b1;
          st_nxt        = BK_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      BK_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          st_nxt        = BK_IDLE;
        end
      end
      default: begin
        st_nxt        = BK_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ap_r   <= ap_nxt;
    wt_r   <= wt_nxt;
    remx_r <= remx_nxt;
    remy_r <= remy_nxt;
    div_r  <= div_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    satx_r <= satx_nxt;
    saty_r <= saty_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r == (st_r == BK_OUT))
    else $error("result valid out of step with back-end state");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == BK_IDLE) && q_valid)
    else $error("job taken outside idle");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.centroid_valid) |->
      (out_r.centroid_x == '0) && (out_r.centroid_y == '0) && (out_r.aperture_sum == '0))
    else $error("empty aperture with nonzero centroid");

endmodule

`default_nettype wire

// File: hdl/window_photometry_centroid_unit.sv
// Top level of the window photometry and centroid unit.
// Ties the front end, the job queue and the divider back end together.
// Uses wpc_pkg, wpc_front, wpc_queue, wpc_back.
//
// Usage: feed the pixels of a WINDOW_SIDE x WINDOW_SIDE window in row-major
// order on the in_ channel, one word per pixel (sample and mask weight).
// The front end takes one word per cycle while in_stall is low and keeps
// the position and the aperture, weighted and moment sums. At the last
// pixel of a window it pushes the sums into a two-entry job queue and
// clears for the next window. The back end pops a job and divides both
// moments by the aperture sum with a restoring divider, one quotient bit per
// cycle for both axes at once, 11 quotient bits per axis; an empty aperture
// skips the division. One result word per window appears on out_.
// Sustained rate: one pixel per cycle while the divider and the output keep
// up; for small windows the divider sets the pace and in_stall rises while
// the queue is full.
// When out_stall is high the result word holds; the front end keeps taking
// pixels until the queue fills. Reset (rst_n low, synchronous) clears the
// position, the sums, the queue and the result valid.
`timescale 1ns / 1ps
`default_nettype none

module window_photometry_centroid_unit
  import wpc_pkg::*;
#(
  parameter int WINDOW_SIDE = WPC_WINDOW_SIDE
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  // Front end to queue
  logic q_push;
  job_t q_push_job;
  logic q_full;

  // Queue to back end
  logic q_pop;
  logic q_valid;
  job_t q_job;

  // Accept pixels and build the window sums
  wpc_front #(
    .WINDOW_SIDE(WINDOW_SIDE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_push_job)
  );

  // Hold finished windows so the front end does not wait on the divider
  wpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_job)
  );

  // Divide and drive the result word
  wpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for window_photometry_centroid_unit: streams pixel windows,
// predicts photometry sums and centroids, and checks every result word field by field.
// Depends on wpc_pkg and the RTL top level with its front end, queue and back end.

module testbench;
  import wpc_pkg::*;

  localparam int SIDE          = WPC_WINDOW_SIDE;
  localparam int WINDOW_PIXELS = SIDE * SIDE;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 10;
  localparam longint unsigned CEN_MAX = (64'd1 << CEN_W) - 1;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  window_photometry_centroid_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Words waiting to be offered, and result words the model says must come out
  in_word_t  pixel_q[$];
  out_word_t window_results_q[$];

  // Idling knobs, in percent of cycles; set per phase by the stimulus block
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long receiver hold-off: the stimulus block bumps the request count,
  // the receiver process notices the change and counts the hold down itself
  int hold_req_seq = 0;
  int hold_ack_seq = 0;
  int hold_left    = 0;

  logic in_taken = 1'b0;

  // Run statistics
  int fault_count     = 0;
  int pixels_taken    = 0;
  int results_seen    = 0;
  int empty_windows   = 0;
  int clamped_windows = 0;
  int stalled_offers  = 0;
  int cycle_count     = 0;

  // Model state: position of the next pixel and the four running sums
  int unsigned     col_pos = 0;
  int unsigned     row_pos = 0;
  longint unsigned ap_acc  = 0;
  longint unsigned wt_acc  = 0;
  longint unsigned col_mom = 0;
  longint unsigned row_mom = 0;

  initial forever #5 clk = ~clk;

  // Accumulators clamp at all-ones of their width instead of wrapping
  function automatic longint unsigned add_clamped(longint unsigned acc, longint unsigned inc,
                                                  int width);
    longint unsigned top;
    top = (64'd1 << width) - 1;
    return (acc + inc > top) ? top : acc + inc;
  endfunction

  // Moment over aperture with 8 fraction bits, halves rounded up, clamped to the field
  function automatic logic [CEN_W-1:0] centroid_of_moment(longint unsigned mom,
                                                          longint unsigned ap);
    longint unsigned q;
    q = ((mom << CEN_FRAC) + (ap >> 1)) / ap;
    return (q > CEN_MAX) ? CEN_MAX[CEN_W-1:0] : q[CEN_W-1:0];
  endfunction

  // Fold one accepted word into the window sums; on the last pixel of the
  // window queue the expected result word and clear for the next window.
  task automatic track_window(input in_word_t w);
    longint unsigned pix;
    longint unsigned wgt;
    out_word_t       res;
    bit              at_end;
    pix = w.pixel & ((64'd1 << PIXEL_BITS) - 1);
    wgt = w.weight;
    if (wgt != 0) begin
      ap_acc  = add_clamped(ap_acc, pix, AP_W);
      col_mom = add_clamped(col_mom, pix * (col_pos + 1), MOM_W);
      row_mom = add_clamped(row_mom, pix * (row_pos + 1), MOM_W);
    end
    wt_acc = add_clamped(wt_acc, pix * wgt, WT_W);
    at_end = (col_pos == SIDE - 1) && (row_pos == SIDE - 1);
    if (col_pos == SIDE - 1) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    if (at_end) begin
      res.aperture_sum = ap_acc[AP_W-1:0];
      res.weighted_sum = wt_acc[WT_W-1:0];
      if (ap_acc != 0) begin
        res.centroid_x     = centroid_of_moment(col_mom, ap_acc);
        res.centroid_y     = centroid_of_moment(row_mom, ap_acc);
        res.centroid_valid = 1'b1;
      end else begin
        res.centroid_x     = '0;
        res.centroid_y     = '0;
        res.centroid_valid = 1'b0;
        empty_windows++;
      end
      if (wt_acc == (64'd1 << WT_W) - 1) clamped_windows++;
      window_results_q.push_back(res);
      col_pos = 0;
      row_pos = 0;
      ap_acc  = 0;
      wt_acc  = 0;
      col_mom = 0;
      row_mom = 0;
    end
  endtask

  task automatic note_fault(input string what, input out_word_t want, input out_word_t got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t: %s: expected ap=%0d wt=%0d cx=%0d cy=%0d v=%0b, got ap=%0d wt=%0d cx=%0d cy=%0d v=%0b",
               $realtime, what, want.aperture_sum, want.weighted_sum, want.centroid_x,
               want.centroid_y, want.centroid_valid, got.aperture_sum, got.weighted_sum,
               got.centroid_x, got.centroid_y, got.centroid_valid);
  endtask

  // Sender: change the word only at the falling edge, and only once the
  // current word is gone; hold a stalled word untouched.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_word  <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a requested long hold-off wins over the random stall
  always @(negedge clk) begin
    if (hold_req_seq != hold_ack_seq) begin
      hold_ack_seq <= hold_req_seq;
      hold_left    <= LONG_HOLD;
      out_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: check the result side first, then fold in the word taken at
  // this edge, so a result is never matched against its own window.
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (window_results_q.size() == 0) begin
          note_fault("result word with nothing expected", '0, out_word);
        end else begin
          want = window_results_q.pop_front();
          if (want.aperture_sum   !== out_word.aperture_sum   ||
              want.weighted_sum   !== out_word.weighted_sum   ||
              want.centroid_x     !== out_word.centroid_x     ||
              want.centroid_y     !== out_word.centroid_y     ||
              want.centroid_valid !== out_word.centroid_valid)
            note_fault("result word differs", want, out_word);
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && in_stall) stalled_offers++;
      if (in_valid && !in_stall) begin
        pixels_taken++;
        track_window(in_word);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result words still expected",
               cycle_count, window_results_q.size());
      $display("window_photometry_centroid_unit: mismatch");
      $finish;
    end
  end

  // Wait until every word is taken and every expected result has come out
  task automatic wait_for_drain();
    while (pixel_q.size() != 0 || in_valid || window_results_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_flat_window(input logic [PIX_W-1:0] pix, input logic [WGT_W-1:0] wgt);
    in_word_t w;
    w.pixel  = pix;
    w.weight = wgt;
    repeat (WINDOW_PIXELS) pixel_q.push_back(w);
  endtask

  // A mostly dark window: a faint corner at the first pixel with the smallest
  // weight and a brighter one at the last, so the centroid lands off grid
  task automatic queue_corner_window();
    in_word_t w;
    for (int i = 0; i < WINDOW_PIXELS; i++) begin
      w = '0;
      if (i == 0) begin
        w.pixel  = 1;
        w.weight = 1;
      end else if (i == WINDOW_PIXELS - 1) begin
        w.pixel  = 2;
        w.weight = 9'd256;
      end
      pixel_q.push_back(w);
    end
  endtask

  // One window of random content in one of several shapes
  task automatic queue_random_window();
    int       shape;
    int       pick;
    in_word_t w;
    shape = $urandom_range(9);
    for (int i = 0; i < WINDOW_PIXELS; i++) begin
      case (shape)
        0: begin  // empty aperture: nothing in the mask
          w.pixel  = $urandom;
          w.weight = '0;
        end
        1: begin  // sparse star field: a few lit pixels, any weight
          w.pixel  = ($urandom_range(7) == 0) ? $urandom : 0;
          w.weight = $urandom;
        end
        2: begin  // bright and heavy: pushes the weighted sum toward its clamp
          w.pixel  = 16'hFFFF - $urandom_range(255);
          w.weight = 9'd256 + $urandom_range(255);
        end
        default: begin
          pick = $urandom_range(9);
          if (pick == 0)      w.pixel = '0;
          else if (pick == 1) w.pixel = 16'hFFFF;
          else if (pick == 2) w.pixel = $urandom_range(255);
          else                w.pixel = $urandom;
          pick = $urandom_range(9);
          if (pick <= 1)      w.weight = '0;
          else if (pick <= 7) w.weight = 9'd256;
          else if (pick == 8) w.weight = $urandom_range(255);
          else                w.weight = $urandom_range(511);
        end
      endcase
      pixel_q.push_back(w);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int windows);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (windows) queue_random_window();
    wait_for_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed windows: empty aperture at full brightness, everything at the
    // top of its range so the weighted sum clamps, and a lopsided dark window
    queue_flat_window(16'hFFFF, 9'd0);
    queue_flat_window(16'hFFFF, 9'h1FF);
    queue_corner_window();
    wait_for_drain();

    // Random windows under each idling pattern
    run_phase(0, 0, 9);
    run_phase(45, 0, 9);
    run_phase(0, 45, 9);
    run_phase(6, 6, 7);

    // Back-pressure: hold the result side off while the sender keeps pushing,
    // so the job queue fills and in_stall rises
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_seq   = hold_req_seq + 1;
    repeat (4) queue_random_window();
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (window_results_q.size() != 0) begin
      fault_count += window_results_q.size();
      $display("%0d expected result words never arrived", window_results_q.size());
    end

    $display("Ran %0d pixels through %0d windows (%0d empty, %0d with a clamped weighted sum).",
             pixels_taken, results_seen, empty_windows, clamped_windows);
    $display("Idling phases plus a %0d-cycle output hold; input stalled on %0d offers.",
             LONG_HOLD, stalled_offers);
    if (fault_count == 0) begin
      $display("window_photometry_centroid_unit: match");
    end else begin
      $display("%0d faults in total", fault_count);
      $display("window_photometry_centroid_unit: mismatch");
    end
    $finish;
  end

endmodule
